### rtl/core/slbb_pkg.sv
// Shared types, constants and helpers for the status LED burst blinker.
// No dependencies; every other file of the block imports this package.
package slbb_pkg;

   localparam int TIME_WIDTH     = 32;
   localparam int INTERVAL_WIDTH = 31;
   localparam int DELAY_WIDTH    = 16;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 32;

   typedef logic [TIME_WIDTH-1:0]     time_type;
   typedef logic [INTERVAL_WIDTH-1:0] interval_type;
   typedef logic [DELAY_WIDTH-1:0]    delay_type;

   localparam interval_type RST_HEARTBEAT_INTERVAL = INTERVAL_WIDTH'(60000);
   localparam delay_type    RST_ON_TIME_SLEEPING   = DELAY_WIDTH'(650);
   localparam delay_type    RST_ON_TIME_OK         = DELAY_WIDTH'(450);
   localparam delay_type    RST_ON_TIME_OTHER      = DELAY_WIDTH'(320);
   localparam delay_type    RST_GAP_TIME           = DELAY_WIDTH'(220);
   localparam delay_type    RST_RESTART_DELAY      = DELAY_WIDTH'(250);
   localparam delay_type    RST_SETTLE_DELAY       = DELAY_WIDTH'(10);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_HEARTBEAT_INTERVAL = 3'd0,
      CSR_ON_TIME_SLEEPING   = 3'd1,
      CSR_ON_TIME_OK         = 3'd2,
      CSR_ON_TIME_OTHER      = 3'd3,
      CSR_GAP_TIME           = 3'd4,
      CSR_RESTART_DELAY      = 3'd5,
      CSR_SETTLE_DELAY       = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_OFF      = 3'd0,
      MODE_OK       = 3'd1,
      MODE_HUNGRY   = 3'd2,
      MODE_TIRED    = 3'd3,
      MODE_SLEEPING = 3'd4,
      MODE_DANGER   = 3'd5,
      MODE_BORED    = 3'd6,
      MODE_MAD      = 3'd7
   } mode_type;

   typedef struct packed {
      interval_type heartbeat_interval;
      delay_type    on_time_sleeping;
      delay_type    on_time_ok;
      delay_type    on_time_other;
      delay_type    gap_time;
      delay_type    restart_delay;
      delay_type    settle_delay;
   } cfg_type;

   typedef struct packed {
      time_type now_ms;
      mode_type mode;
      logic     alerts_enabled;
      logic     screen_off;
   } req_item_type;

   typedef struct packed {
      logic [7:0] led_red;
      logic [7:0] led_green;
      logic [7:0] led_blue;
      logic       pulse_on;
      logic       force_backlight_low;
      logic       bursting;
   } rsp_item_type;

   typedef struct packed {
      mode_type    previous_mode;
      time_type    next_heartbeat_time;
      logic        burst_running;
      logic [2:0]  flashes_left;
      logic        flash_lit;
      time_type    next_toggle_time;
      logic        pulse_active;
      logic        screen_was_off;
      logic [23:0] shown_colour;
   } state_type;

   // wrapping add of a delay to a timestamp
   function automatic time_type t_add(input time_type t, input interval_type d);
      return t + time_type'(d);
   endfunction

   // a before b: the wrapped difference is negative
   function automatic logic t_before(input time_type a, input time_type b);
      time_type diff;
      diff = a - b;
      return diff[TIME_WIDTH-1];
   endfunction

   // fixed colour per mode, red in the top byte
   function automatic logic [23:0] mode_colour(input mode_type m);
      logic [23:0] c;
      unique case (m)
         MODE_OFF:      c = {8'd0,   8'd0,  8'd0};
         MODE_OK:       c = {8'd0,   8'd50, 8'd0};
         MODE_HUNGRY:   c = {8'd70,  8'd45, 8'd0};
         MODE_TIRED:    c = {8'd0,   8'd0,  8'd90};
         MODE_SLEEPING: c = {8'd55,  8'd0,  8'd70};
         MODE_DANGER:   c = {8'd110, 8'd0,  8'd0};
         MODE_BORED:    c = {8'd0,   8'd70, 8'd70};
         MODE_MAD:      c = {8'd120, 8'd25, 8'd0};
         default:       c = 24'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] mode_flashes(input mode_type m);
      logic [2:0] n;
      unique case (m)
         MODE_OFF:      n = 3'd0;
         MODE_OK:       n = 3'd1;
         MODE_HUNGRY:   n = 3'd2;
         MODE_TIRED:    n = 3'd3;
         MODE_SLEEPING: n = 3'd1;
         MODE_DANGER:   n = 3'd5;
         MODE_BORED:    n = 3'd2;
         MODE_MAD:      n = 3'd4;
         default:       n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

### rtl/core/status_led_burst_blinker_core.sv
// Top level of the status LED burst blinker: beat register, blinker state and result register.
// Depends on slbb_pkg, slbb_csr and slbb_update.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------------
//   req     | in  | req_tvalid/req_tready| now_ms, mode, alerts_enabled, screen_off
//   rsp     | out | rsp_tvalid/rsp_tready| led_red/green/blue, pulse_on, force_low, bursting
//   csr     | in  | csr_wr_en            | csr_index, csr_wdata (no read-back)
//
// Each beat passes through the input register, then through the update logic (five parallel
// timestamp adds and compares) into the result register. One beat per cycle is sustained
// while rsp_tready is high. Reset is synchronous and returns the blinker state, the valid
// flags and the configuration to their defaults; the beat data registers are not reset.
// A stalled rsp side holds the result; req_tready drops only while both stages are full.
module status_led_burst_blinker_core
   import slbb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: now_ms[31:0], mode[34:32], alerts_enabled[35], screen_off[36], zero pad
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // rsp_tdata: led_red[7:0], led_green[15:8], led_blue[23:16], pulse_on[24],
   //            force_backlight_low[25], bursting[26], zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [INTERVAL_WIDTH-1:0] csr_wdata
);

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item_ff;
   logic         item_valid_ff;
   state_type    state_ff;
   state_type    state_in;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_load;
   logic         item_take;

   slbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // unpack the request beat
   assign req_item.now_ms         = req_tdata[TIME_WIDTH-1:0];
   assign req_item.mode           = mode_type'(req_tdata[34:32]);
   assign req_item.alerts_enabled = req_tdata[35];
   assign req_item.screen_off     = req_tdata[36];

   // result register may load when empty or being drained this cycle
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign item_take  = item_valid_ff && rsp_load;
   assign req_tready = !item_valid_ff || rsp_load;

   // input register: advance whenever the held beat moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   slbb_update u_update (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result)
   );

   // blinker state: commit only when a beat is applied
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (item_take) begin
         state_ff <= state_in;
      end
   end

   // result register: hold while rsp is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.bursting, rsp_ff.force_backlight_low, rsp_ff.pulse_on,
                        rsp_ff.led_blue, rsp_ff.led_green, rsp_ff.led_red};

endmodule

### rtl/core/slbb_csr.sv
// Configuration register file of the status LED burst blinker.
// Depends on slbb_pkg for the register index codes and reset values.
module slbb_csr
   import slbb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [INTERVAL_WIDTH-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEARTBEAT_INTERVAL: cfg_in.heartbeat_interval = csr_wdata;
            CSR_ON_TIME_SLEEPING:   cfg_in.on_time_sleeping = csr_wdata[DELAY_WIDTH-1:0];
            CSR_ON_TIME_OK:         cfg_in.on_time_ok = csr_wdata[DELAY_WIDTH-1:0];
            CSR_ON_TIME_OTHER:      cfg_in.on_time_other = csr_wdata[DELAY_WIDTH-1:0];
            CSR_GAP_TIME:           cfg_in.gap_time = csr_wdata[DELAY_WIDTH-1:0];
            CSR_RESTART_DELAY:      cfg_in.restart_delay = csr_wdata[DELAY_WIDTH-1:0];
            CSR_SETTLE_DELAY:       cfg_in.settle_delay = csr_wdata[DELAY_WIDTH-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heartbeat_interval <= RST_HEARTBEAT_INTERVAL;
         cfg_ff.on_time_sleeping   <= RST_ON_TIME_SLEEPING;
         cfg_ff.on_time_ok         <= RST_ON_TIME_OK;
         cfg_ff.on_time_other      <= RST_ON_TIME_OTHER;
         cfg_ff.gap_time           <= RST_GAP_TIME;
         cfg_ff.restart_delay      <= RST_RESTART_DELAY;
         cfg_ff.settle_delay       <= RST_SETTLE_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/slbb_update.sv
// Next-state and result logic for one update beat of the burst blinker.
// Purely combinational; depends on slbb_pkg for types and time helpers.
module slbb_update
   import slbb_pkg::*;
(
   input  cfg_type      cfg,
   input  state_type    state,
   input  req_item_type item,
   output state_type    state_next,
   output rsp_item_type result
);

   time_type  sum_restart;
   time_type  sum_interval;
   time_type  sum_settle;
   time_type  sum_on;
   time_type  sum_gap;
   delay_type on_time;
   logic      go;
   logic      force_low;
   state_type s;

   always_comb begin
      unique case (item.mode)
         MODE_SLEEPING: on_time = cfg.on_time_sleeping;
         MODE_OK:       on_time = cfg.on_time_ok;
         default:       on_time = cfg.on_time_other;
      endcase
   end

   // all candidate deadlines are formed side by side off the timestamp
   assign sum_restart  = t_add(item.now_ms, INTERVAL_WIDTH'(cfg.restart_delay));
   assign sum_interval = t_add(item.now_ms, cfg.heartbeat_interval);
   assign sum_settle   = t_add(item.now_ms, INTERVAL_WIDTH'(cfg.settle_delay));
   assign sum_on       = t_add(item.now_ms, INTERVAL_WIDTH'(on_time));
   assign sum_gap      = t_add(item.now_ms, INTERVAL_WIDTH'(cfg.gap_time));

   always_comb begin
      s         = state;
      force_low = 1'b0;
      go        = 1'b0;

      // screen bit first: cancel the pulse when the display comes back
      if (state.screen_was_off && !item.screen_off) begin
         s.pulse_active = 1'b0;
      end
      s.screen_was_off = item.screen_off;

      if (!item.alerts_enabled) begin
         s.previous_mode       = MODE_OFF;
         s.next_heartbeat_time = '0;
         s.burst_running       = 1'b0;
         s.flashes_left        = 3'd0;
         s.flash_lit           = 1'b0;
         s.next_toggle_time    = '0;
         s.shown_colour        = 24'd0;
         force_low             = item.screen_off;
         if (item.screen_off) s.pulse_active = 1'b0;
      end else begin
         if (item.mode != state.previous_mode) begin
            s.previous_mode       = item.mode;
            s.next_heartbeat_time = sum_restart;
            s.burst_running       = 1'b0;
            s.flashes_left        = 3'd0;
            s.flash_lit           = 1'b0;
            s.next_toggle_time    = '0;
            s.shown_colour        = 24'd0;
            if (item.screen_off) s.pulse_active = 1'b0;
         end
         if (item.mode == MODE_OFF) begin
            s.shown_colour = 24'd0;
            force_low      = item.screen_off;
            if (item.screen_off) s.pulse_active = 1'b0;
         end else begin
            go = 1'b1;
            if (!s.burst_running) begin
               // zero means unscheduled
               if (s.next_heartbeat_time == '0) begin
                  s.next_heartbeat_time = sum_interval;
               end
               if (t_before(item.now_ms, s.next_heartbeat_time)) begin
                  s.shown_colour = 24'd0;
                  force_low      = item.screen_off;
                  if (item.screen_off) s.pulse_active = 1'b0;
                  go = 1'b0;
               end else begin
                  s.burst_running    = 1'b1;
                  s.flashes_left     = mode_flashes(item.mode);
                  s.flash_lit        = 1'b0;
                  s.next_toggle_time = sum_settle;
                  if (item.screen_off) s.pulse_active = 1'b1;
               end
            end
            if (go && !t_before(item.now_ms, s.next_toggle_time)) begin
               if (s.flashes_left == 3'd0) begin
                  s.burst_running       = 1'b0;
                  s.next_heartbeat_time = sum_interval;
                  s.shown_colour        = 24'd0;
                  force_low             = item.screen_off;
                  if (item.screen_off) s.pulse_active = 1'b0;
               end else if (!s.flash_lit) begin
                  s.flash_lit        = 1'b1;
                  s.shown_colour     = mode_colour(item.mode);
                  s.next_toggle_time = sum_on;
                  if (item.screen_off) s.pulse_active = 1'b1;
               end else begin
                  s.flash_lit        = 1'b0;
                  s.shown_colour     = 24'd0;
                  s.flashes_left     = s.flashes_left - 3'd1;
                  s.next_toggle_time = sum_gap;
               end
            end
         end
      end

      state_next                 = s;
      result.led_red             = s.shown_colour[23:16];
      result.led_green           = s.shown_colour[15:8];
      result.led_blue            = s.shown_colour[7:0];
      result.pulse_on            = s.pulse_active;
      result.force_backlight_low = force_low;
      result.bursting            = s.burst_running;
   end

endmodule

### rtl/core/slbb_checker.sv
// Port-level checks for the status LED burst blinker, bound to the top level.
// Depends on slbb_pkg for port widths.
module slbb_checker
   import slbb_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a waiting request is refused only while a result beat sits stalled
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req beat refused without rsp back pressure");

   // a lit LED only appears inside a burst
   a_lit_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[23:0] != 24'd0) |-> rsp_tdata[26])
      else $error("LED lit outside a burst");

   // forcing the backlight low always comes with a dark LED and no pulse
   a_low_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |-> (rsp_tdata[23:0] == 24'd0) && !rsp_tdata[24])
      else $error("backlight forced low while LED lit or pulse active");

endmodule

bind status_led_burst_blinker_core slbb_checker u_slbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
